FILE: src/sdt_pkg.sv
// Package for the single/double tap detector.
// Holds the transaction payload types, the slot entry type and shared constants.
// Depends on nothing; every other file imports it.
package sdt_pkg;

   localparam int KEY_W = 32;
   localparam int POS_W = 8;
   localparam int TIME_W = 32;
   localparam int TERM_W = 16;
   localparam int TAP_W = 2;
   localparam int REQ_W = 2;
   localparam int MAX_RESULTS = 16;
   localparam int CNT_W = 5;

   localparam logic [TAP_W-1:0] TAP_LIMIT = 2'd2;
   localparam logic [TERM_W-1:0] TERM_RESET = 16'd200;

   localparam logic [REQ_W-1:0] REQ_PRESS = 2'd0;
   localparam logic [REQ_W-1:0] REQ_RELEASE = 2'd1;
   localparam logic [REQ_W-1:0] REQ_TICK = 2'd2;

   localparam logic STATUS_KEY = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   typedef struct packed {
      logic [REQ_W-1:0]  req_type;
      logic [POS_W-1:0]  key_position;
      logic [KEY_W-1:0]  one_tap_code;
      logic [KEY_W-1:0]  two_tap_code;
      logic [TIME_W-1:0] event_time;
   } sdt_request_type;

   typedef struct packed {
      logic              status;
      logic [KEY_W-1:0]  out_key;
      logic              out_pressed;
      logic [TIME_W-1:0] out_time;
      logic              last;
   } sdt_response_type;

   typedef struct packed {
      logic              used;
      logic [POS_W-1:0]  position;
      logic [KEY_W-1:0]  single_code;
      logic [KEY_W-1:0]  double_code;
      logic [TAP_W-1:0]  press_total;
      logic              held;
      logic              decided;
      logic              chose_double;
      logic              armed;
      logic [TIME_W-1:0] deadline;
   } sdt_slot_type;

   typedef struct packed {
      logic              match;
      logic              free;
      logic              due;
      logic [TIME_W-1:0] new_deadline;
   } sdt_eval_type;

endpackage

FILE: src/sdt_slot_table.sv
// Slot table of the single/double tap detector: one entry per tracked key position.
// Flags are cleared by reset; codes, position and deadline have no reset and take every write.
// Depends on sdt_pkg.
module sdt_slot_table
   import sdt_pkg::*;
#(
   parameter int SLOTS = 8,
   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [IDX_W-1:0] rd_idx,
   output sdt_slot_type     rd_entry,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_idx,
   input  sdt_slot_type     wr_entry
);

   logic              used_ff         [SLOTS];
   logic [TAP_W-1:0]  press_total_ff  [SLOTS];
   logic              held_ff         [SLOTS];
   logic              decided_ff      [SLOTS];
   logic              chose_double_ff [SLOTS];
   logic              armed_ff        [SLOTS];
   logic [POS_W-1:0]  position_ff     [SLOTS];
   logic [KEY_W-1:0]  single_ff       [SLOTS];
   logic [KEY_W-1:0]  double_ff       [SLOTS];
   logic [TIME_W-1:0] deadline_ff     [SLOTS];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            used_ff[i]         <= 1'b0;
            press_total_ff[i]  <= '0;
            held_ff[i]         <= 1'b0;
            decided_ff[i]      <= 1'b0;
            chose_double_ff[i] <= 1'b0;
            armed_ff[i]        <= 1'b0;
         end
      end else if (wr_en) begin
         used_ff[wr_idx]         <= wr_entry.used;
         press_total_ff[wr_idx]  <= wr_entry.press_total;
         held_ff[wr_idx]         <= wr_entry.held;
         decided_ff[wr_idx]      <= wr_entry.decided;
         chose_double_ff[wr_idx] <= wr_entry.chose_double;
         armed_ff[wr_idx]        <= wr_entry.armed;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         position_ff[wr_idx] <= wr_entry.position;
         single_ff[wr_idx]   <= wr_entry.single_code;
         double_ff[wr_idx]   <= wr_entry.double_code;
         deadline_ff[wr_idx] <= wr_entry.deadline;
      end
   end

   always_comb begin
      rd_entry.used         = used_ff[rd_idx];
      rd_entry.position     = position_ff[rd_idx];
      rd_entry.single_code  = single_ff[rd_idx];
      rd_entry.double_code  = double_ff[rd_idx];
      rd_entry.press_total  = press_total_ff[rd_idx];
      rd_entry.held         = held_ff[rd_idx];
      rd_entry.decided      = decided_ff[rd_idx];
      rd_entry.chose_double = chose_double_ff[rd_idx];
      rd_entry.armed        = armed_ff[rd_idx];
      rd_entry.deadline     = deadline_ff[rd_idx];
   end

endmodule

FILE: src/sdt_slot_eval.sv
// Shared slot evaluation unit: position compare, wrap-safe deadline check and deadline sum.
// One slot entry is evaluated per cycle under control of the sequencer, which may hold it on a stall.
// Depends on sdt_pkg.
module sdt_slot_eval
   import sdt_pkg::*;
(
   input  sdt_slot_type      entry,
   input  logic [POS_W-1:0]  position,
   input  logic [TIME_W-1:0] now,
   input  logic [TERM_W-1:0] term,
   output sdt_eval_type      result
);

   logic [TIME_W-1:0] elapsed;

   always_comb begin
      elapsed = now - entry.deadline;
      result.match = entry.used && (entry.position == position);
      result.free = !entry.used;
      result.due = entry.used && entry.armed && !entry.decided && !elapsed[TIME_W-1];
      result.new_deadline = now + TIME_W'(term);
   end

endmodule

FILE: src/single_double_tap_detector.sv
// Single/double tap detector. A press or release transaction walks the slot table one
// slot per cycle through a shared compare unit until a match, then updates the slot
// in S_ACT and delivers its result from S_FLUSH. A tick walks the slots the same way,
// taking an extra step for each fired slot whose key is already up, plus a final
// flush step; at most 16 results are produced per tick. A tick step or the flush
// waits only while the result register is held by rsp_ready low.
// Depends on sdt_pkg, sdt_slot_table, sdt_slot_eval.
module single_double_tap_detector
   import sdt_pkg::*;
#(
   parameter int SLOTS = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  sdt_request_type     req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output sdt_response_type    rsp_data,
   input  logic                csr_wr_en,
   input  logic [TERM_W-1:0]   csr_wr_data
);

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SCAN  = 3'd1;
   localparam logic [2:0] S_ACT   = 3'd2;
   localparam logic [2:0] S_TICK  = 3'd3;
   localparam logic [2:0] S_FLUSH = 3'd4;

   logic [2:0]        state_ff, state_in;
   logic [TERM_W-1:0] term_ff;
   sdt_request_type   req_ff, req_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [IDX_W-1:0]  free_idx_ff, free_idx_in;
   logic              found_ff, found_in;
   logic              free_found_ff, free_found_in;
   logic              phase_ff, phase_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   sdt_response_type  pend_ff, pend_in;
   logic              pend_valid_ff, pend_valid_in;
   sdt_response_type  rsp_data_ff, rsp_data_in;
   logic              rsp_valid_ff, rsp_valid_in;

   sdt_slot_type      entry;
   sdt_slot_type      base;
   sdt_slot_type      wr_entry;
   logic              wr_en;
   sdt_eval_type      ev;
   logic              out_free;
   logic              out_load;
   sdt_response_type  out_data;
   sdt_response_type  new_rsp;
   logic              can_push;
   logic [TAP_W-1:0]  next_tap;

   sdt_slot_table #(.SLOTS(SLOTS)) u_table (
      .clock    (clock),
      .reset    (reset),
      .rd_idx   (idx_ff),
      .rd_entry (entry),
      .wr_en    (wr_en),
      .wr_idx   (idx_ff),
      .wr_entry (wr_entry)
   );

   sdt_slot_eval u_eval (
      .entry    (entry),
      .position (req_ff.key_position),
      .now      (req_ff.event_time),
      .term     (term_ff),
      .result   (ev)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign can_push = !pend_valid_ff || out_free;

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      idx_in        = idx_ff;
      free_idx_in   = free_idx_ff;
      found_in      = found_ff;
      free_found_in = free_found_ff;
      phase_in      = phase_ff;
      cnt_in        = cnt_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      wr_en         = 1'b0;
      wr_entry      = entry;
      base          = entry;
      out_load      = 1'b0;
      out_data      = pend_ff;
      new_rsp       = '0;
      next_tap      = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in        = req_data;
               idx_in        = '0;
               found_in      = 1'b0;
               free_found_in = 1'b0;
               phase_in      = 1'b0;
               cnt_in        = '0;
               priority case (req_data.req_type)
                  REQ_PRESS, REQ_RELEASE: state_in = S_SCAN;
                  REQ_TICK:               state_in = S_TICK;
                  default:                state_in = S_IDLE;
               endcase
            end
         end

         S_SCAN: begin
            if (ev.match) begin
               found_in = 1'b1;
               state_in = S_ACT;
            end else begin
               if (ev.free && !free_found_ff) begin
                  free_found_in = 1'b1;
                  free_idx_in   = idx_ff;
               end
               if (idx_ff == LAST_IDX) begin
                  free_found_in = free_found_ff || ev.free;
                  idx_in        = free_found_ff ? free_idx_ff : idx_ff;
                  state_in      = S_ACT;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end

         S_ACT: begin
            state_in = S_FLUSH;
            if (req_ff.req_type == REQ_PRESS) begin
               if (!found_ff && !free_found_ff) begin
                  new_rsp.status = STATUS_FULL;
                  pend_in        = new_rsp;
                  pend_valid_in  = 1'b1;
               end else begin
                  if (!found_ff) begin
                     base.used         = 1'b1;
                     base.position     = req_ff.key_position;
                     base.single_code  = req_ff.one_tap_code;
                     base.double_code  = req_ff.two_tap_code;
                     base.press_total  = '0;
                     base.held         = 1'b0;
                     base.decided      = 1'b0;
                     base.chose_double = 1'b0;
                     base.armed        = 1'b0;
                  end
                  next_tap = (base.press_total < TAP_LIMIT) ? base.press_total + 1'b1
                                                            : base.press_total;
                  wr_entry             = base;
                  wr_entry.held        = 1'b1;
                  wr_entry.armed       = 1'b0;
                  wr_entry.press_total = next_tap;
                  if (next_tap >= TAP_LIMIT) begin
                     wr_entry.decided      = 1'b1;
                     wr_entry.chose_double = 1'b1;
                     new_rsp.status        = STATUS_KEY;
                     new_rsp.out_key       = base.double_code;
                     new_rsp.out_pressed   = 1'b1;
                     new_rsp.out_time      = req_ff.event_time;
                     pend_in               = new_rsp;
                     pend_valid_in         = 1'b1;
                  end else begin
                     wr_entry.deadline = ev.new_deadline;
                     wr_entry.armed    = 1'b1;
                  end
                  wr_en = 1'b1;
               end
            end else if (found_ff) begin
               wr_entry      = entry;
               wr_entry.held = 1'b0;
               if (entry.decided) begin
                  new_rsp.status        = STATUS_KEY;
                  new_rsp.out_key       = entry.chose_double ? entry.double_code
                                                             : entry.single_code;
                  new_rsp.out_pressed   = 1'b0;
                  new_rsp.out_time      = req_ff.event_time;
                  pend_in               = new_rsp;
                  pend_valid_in         = 1'b1;
                  wr_entry.used         = 1'b0;
                  wr_entry.press_total  = '0;
                  wr_entry.decided      = 1'b0;
                  wr_entry.chose_double = 1'b0;
                  wr_entry.armed        = 1'b0;
               end
               wr_en = 1'b1;
            end
         end

         S_TICK: begin
            new_rsp.status      = STATUS_KEY;
            new_rsp.out_key     = entry.single_code;
            new_rsp.out_pressed = !phase_ff;
            new_rsp.out_time    = entry.deadline;
            if (phase_ff) begin
               if (can_push) begin
                  out_load              = pend_valid_ff;
                  pend_in               = new_rsp;
                  pend_valid_in         = 1'b1;
                  cnt_in                = cnt_ff + 1'b1;
                  wr_entry.used         = 1'b0;
                  wr_entry.press_total  = '0;
                  wr_entry.held         = 1'b0;
                  wr_entry.decided      = 1'b0;
                  wr_entry.chose_double = 1'b0;
                  wr_entry.armed        = 1'b0;
                  wr_en                 = 1'b1;
                  phase_in              = 1'b0;
                  if (idx_ff == LAST_IDX) begin
                     state_in = S_FLUSH;
                  end else begin
                     idx_in = idx_ff + 1'b1;
                  end
               end
            end else if (ev.due && (cnt_ff > CNT_W'(MAX_RESULTS - 2))) begin
               state_in = S_FLUSH;
            end else if (ev.due) begin
               if (can_push) begin
                  out_load              = pend_valid_ff;
                  pend_in               = new_rsp;
                  pend_valid_in         = 1'b1;
                  cnt_in                = cnt_ff + 1'b1;
                  wr_entry.armed        = 1'b0;
                  wr_entry.decided      = 1'b1;
                  wr_entry.chose_double = 1'b0;
                  wr_en                 = 1'b1;
                  if (!entry.held) begin
                     phase_in = 1'b1;
                  end else if (idx_ff == LAST_IDX) begin
                     state_in = S_FLUSH;
                  end else begin
                     idx_in = idx_ff + 1'b1;
                  end
               end
            end else if (idx_ff == LAST_IDX) begin
               state_in = S_FLUSH;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end

         S_FLUSH: begin
            if (!pend_valid_ff) begin
               state_in = S_IDLE;
            end else if (out_free) begin
               out_load      = 1'b1;
               out_data.last = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_data_in  = out_data;
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         term_ff       <= TERM_RESET;
         found_ff      <= 1'b0;
         free_found_ff <= 1'b0;
         phase_ff      <= 1'b0;
         cnt_ff        <= '0;
         idx_ff        <= '0;
         free_idx_ff   <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         if (csr_wr_en) begin
            term_ff <= csr_wr_data;
         end
         found_ff      <= found_in;
         free_found_ff <= free_found_in;
         phase_ff      <= phase_in;
         cnt_ff        <= cnt_in;
         idx_ff        <= idx_in;
         free_idx_ff   <= free_idx_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      pend_ff     <= pend_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule
